@@ design/srwc_pkg.sv @@
package srwc_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 2048;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   // Field widths.
   localparam int MODE_W     = 2;
   localparam int ADDR_W     = 64;
   localparam int LEN_W      = 32;
   localparam int FILL_W     = 8;
   localparam int CNT_W      = 11;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 120;

   // Operation codes carried in the request tuser.
   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_ADJUST = 2'd2
   } mode_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_END,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // a request transaction completes this cycle
      logic walk;       // the accepted request starts a table walk
      logic step_start; // apply the window-start check for the current entry
      logic step_end;   // apply the window-end check and advance the entry
      logic load_walk;  // move the walked window into the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_needed; // adjust request with stored ranges and a nonzero window
      logic more;        // another entry must be visited after this one
      logic rsp_valid;   // the response register holds a result
   } status_type;

endpackage

@@ design/srwc_ctrl.sv @@
module srwc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 rsp_tready,
   input  srwc_pkg::status_type status,
   output srwc_pkg::cmd_type    cmd
);

   srwc_pkg::state_type state_ff, state_in;
   logic out_free;
   logic accept;

   // The response register can take a result when empty or being drained.
   assign out_free   = !status.rsp_valid || rsp_tready;
   assign req_tready = (state_ff == srwc_pkg::ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srwc_pkg::ST_IDLE: begin
            if (accept && status.walk_needed) begin
               state_in = srwc_pkg::ST_START;
            end
         end
         srwc_pkg::ST_START: begin
            state_in = srwc_pkg::ST_END;
         end
         srwc_pkg::ST_END: begin
            state_in = status.more ? srwc_pkg::ST_START : srwc_pkg::ST_RESP;
         end
         srwc_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = srwc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srwc_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands.
   always_comb begin
      cmd            = '0;
      cmd.accept     = accept;
      cmd.walk       = accept && status.walk_needed;
      cmd.step_start = (state_ff == srwc_pkg::ST_START);
      cmd.step_end   = (state_ff == srwc_pkg::ST_END);
      cmd.load_walk  = (state_ff == srwc_pkg::ST_RESP) && out_free;
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srwc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/srwc_datapath.sv @@
module srwc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [srwc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [srwc_pkg::MODE_W-1:0]         req_tuser,
   input  logic                                csr_wr_en,
   input  logic [srwc_pkg::FILL_W-1:0]         csr_wr_data,
   input  logic                                rsp_tready,
   input  srwc_pkg::cmd_type                   cmd,
   output srwc_pkg::status_type                status,
   output logic                                rsp_tvalid,
   output logic [srwc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int AW = srwc_pkg::ADDR_W;
   localparam int LW = srwc_pkg::LEN_W;
   localparam int IW = srwc_pkg::IDX_W;

   // Range table, one array per bound.
   logic [AW-1:0] range_first [srwc_pkg::TABLE_DEPTH];
   logic [AW-1:0] range_last  [srwc_pkg::TABLE_DEPTH];

   logic [IW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 last_hi_ff, last_hi_in;
   logic [srwc_pkg::FILL_W-1:0]   fill_ff;
   logic [IW-1:0]                 idx_ff, idx_in;
   logic [AW-1:0]                 rd_first_ff, rd_last_ff;
   logic [AW-1:0]                 win_start_ff, win_start_in;
   logic [LW-1:0]                 win_len_ff, win_len_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                 rsp_start_ff, rsp_start_in;
   logic [LW-1:0]                 rsp_len_ff, rsp_len_in;
   logic [IW-1:0]                 rsp_count_ff, rsp_count_in;
   logic [srwc_pkg::FILL_W-1:0]   rsp_fill_ff;

   srwc_pkg::mode_type mode;
   logic [AW-1:0]      req_start;
   logic [LW-1:0]      req_len;
   logic               extend;
   logic [AW-1:0]      new_last;
   logic               wr_first_en, wr_last_en;
   logic [IW-1:0]      wr_first_addr, wr_last_addr;

   logic [AW-1:0] hi_plus1, win_end, trim_end;
   logic          covers_start;
   logic [IW:0]   idx_next;

   assign mode      = srwc_pkg::mode_type'(req_tuser);
   assign req_start = req_tdata[AW-1:0];
   assign req_len   = req_tdata[AW+LW-1:AW];

   // Append or extend logic for add requests; a clear request empties the table count.
   always_comb begin
      extend        = (count_ff != '0) && (req_start == last_hi_ff + 1'b1);
      new_last      = req_start + {{(AW-LW){1'b0}}, req_len} - 1'b1;
      wr_first_en   = 1'b0;
      wr_last_en    = 1'b0;
      wr_first_addr = count_ff;
      wr_last_addr  = count_ff;
      count_in      = count_ff;
      last_hi_in    = last_hi_ff;
      if (cmd.accept) begin
         case (mode)
            srwc_pkg::MODE_CLEAR: begin
               count_in = '0;
            end
            srwc_pkg::MODE_ADD: begin
               if (extend) begin
                  wr_last_en   = 1'b1;
                  wr_last_addr = count_ff - 1'b1;
                  last_hi_in   = last_hi_ff + {{(AW-LW){1'b0}}, req_len};
               end else begin
                  wr_first_en = 1'b1;
                  wr_last_en  = 1'b1;
                  last_hi_in  = new_last;
                  if (count_ff == IW'(srwc_pkg::TABLE_DEPTH - 1)) begin
                     count_in = '0;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // Window update for one table entry, split over a start and an end step; a walk loads the request window.
   always_comb begin
      hi_plus1     = rd_last_ff + 1'b1;
      win_end      = win_start_ff + {{(AW-LW){1'b0}}, win_len_ff};
      covers_start = (rd_first_ff <= win_start_ff) && (rd_last_ff >= win_start_ff);
      trim_end     = win_end - 1'b1;
      win_start_in = win_start_ff;
      win_len_in   = win_len_ff;
      if (cmd.walk) begin
         win_start_in = req_start;
         win_len_in   = req_len;
      end else if (cmd.step_start) begin
         if (covers_start) begin
            if (hi_plus1 > win_end) begin
               win_len_in = '0;
            end else begin
               win_len_in   = win_len_ff - LW'(hi_plus1 - win_start_ff);
               win_start_in = hi_plus1;
            end
         end
      end else if (cmd.step_end) begin
         if ((win_len_ff != '0) && (rd_first_ff < win_end) && (rd_last_ff >= trim_end)) begin
            win_len_in = LW'(rd_first_ff - win_start_ff);
         end
      end
   end

   // Entry index; the table is read at the next index, so read data lines up with the index register.
   always_comb begin
      idx_next = {1'b0, idx_ff} + 1'b1;
      idx_in   = idx_ff;
      if (cmd.walk) begin
         idx_in = '0;
      end else if (cmd.step_end) begin
         idx_in = idx_next[IW-1:0];
      end
   end

   assign status.walk_needed = (mode == srwc_pkg::MODE_ADJUST) && (count_ff != '0) &&
                               (req_len != '0);
   assign status.more        = (idx_next < {1'b0, count_ff}) && (win_len_in != '0);
   assign status.rsp_valid   = rsp_valid_ff;

   // Response register: loaded directly at accept or at the end of a walk.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.accept && !cmd.walk) begin
         rsp_valid_in = 1'b1;
         rsp_start_in = req_start;
         rsp_len_in   = req_len;
         rsp_count_in = count_in;
      end else if (cmd.load_walk) begin
         rsp_valid_in = 1'b1;
         rsp_start_in = win_start_ff;
         rsp_len_in   = win_len_ff;
         rsp_count_in = count_ff;
      end
   end

   // Table writes and registered reads.
   always_ff @(posedge clock) begin
      if (wr_first_en) begin
         range_first[wr_first_addr] <= req_start;
      end
      if (wr_last_en) begin
         range_last[wr_last_addr] <= extend ? last_hi_in : new_last;
      end
      rd_first_ff <= range_first[idx_in];
      rd_last_ff  <= range_last[idx_in];
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            fill_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      last_hi_ff   <= last_hi_in;
      idx_ff       <= idx_in;
      win_start_ff <= win_start_in;
      win_len_ff   <= win_len_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_count_ff <= rsp_count_in;
      if ((cmd.accept && !cmd.walk) || cmd.load_walk) begin
         rsp_fill_ff <= fill_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, srwc_pkg::CNT_W'(rsp_count_ff), rsp_fill_ff, rsp_len_ff,
                        rsp_start_ff};

endmodule

@@ design/skip_range_window_clipper.sv @@
// Clear, add and adjust requests with nothing to walk give their result one cycle after
// acceptance; the next request is taken in the following cycle, so one per cycle.
// An adjust request that walks the table visits up to TABLE_DEPTH - 1 entries, since at
// most TABLE_DEPTH - 1 entries are stored: each entry costs a start step and an end step on
// the table read port. A new request is taken only when no walk is in progress and the response register is free.
// Reset is synchronous and active high; it empties the table count, zeroes the fill byte and
// drops a pending result. Table contents are not cleared and need no clearing pass.
module skip_range_window_clipper (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: start_req[63:0], length[95:64]
   input  logic [srwc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: mode[1:0]
   input  logic [srwc_pkg::MODE_W-1:0]       req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata: new_start[63:0], new_length[95:64], fill[103:96], entry_count[114:104]
   output logic [srwc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  logic [srwc_pkg::FILL_W-1:0]       csr_wr_data
);

   srwc_pkg::cmd_type    cmd;
   srwc_pkg::status_type status;

   // Sequencer for the table walk and the response handshake.
   srwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Range table, window arithmetic and response register.
   srwc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

@@ design/srwc_checker.sv @@
module srwc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic [srwc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic [srwc_pkg::MODE_W-1:0]       req_tuser,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [srwc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready
);

   logic req_xfer;
   assign req_xfer = req_tvalid && req_tready;

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Reset drops any pending response.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A clear transaction answers in the next cycle with an empty table.
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_tuser == srwc_pkg::MODE_CLEAR)
      |=> rsp_tvalid && (rsp_tdata[114:104] == '0))
      else $error("clear did not report an empty table");

   // Non-adjust transactions echo the start address in the next cycle.
   a_echo_start: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_tuser != srwc_pkg::MODE_ADJUST)
      |=> rsp_tvalid && (rsp_tdata[63:0] == $past(req_tdata[63:0])))
      else $error("start address not echoed");

endmodule

bind skip_range_window_clipper srwc_checker u_srwc_checker (.*);
